// ----- sv/twc_pkg.sv -----
`default_nettype none
package twc_pkg;
	localparam int NEAR_LINES = 256;
	localparam int FAR_LINES = 256;
	localparam int WPL = 16;
	localparam int MEM_WORDS = 16384;
	localparam int NIW = 8;
	localparam int FIW = 8;
	localparam int WW = 4;
	localparam int TW = 2;
	localparam int CFGW = 16;
	localparam int CFG_IDXW = 3;
	localparam int COSTW = 20;

	localparam logic [CFG_IDXW-1:0] REG_L1_RD = 3'd0;
	localparam logic [CFG_IDXW-1:0] REG_L1_WR = 3'd1;
	localparam logic [CFG_IDXW-1:0] REG_L2_RD = 3'd2;
	localparam logic [CFG_IDXW-1:0] REG_L2_WR = 3'd3;
	localparam logic [CFG_IDXW-1:0] REG_MEM_RD = 3'd4;
	localparam logic [CFG_IDXW-1:0] REG_MEM_WR = 3'd5;

	localparam logic FUNC_WRITE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_LOOK1,
		ST_N2F,
		ST_LOOK2,
		ST_F2M,
		ST_M2F,
		ST_F2N,
		ST_WORD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [CFGW-1:0] l1_rd;
		logic [CFGW-1:0] l1_wr;
		logic [CFGW-1:0] l2_rd;
		logic [CFGW-1:0] l2_wr;
		logic [CFGW-1:0] mem_rd;
		logic [CFGW-1:0] mem_wr;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic dirty;
		logic [TW-1:0] tag;
	} meta_t;
endpackage
`default_nettype wire

// ----- sv/twc_ram.sv -----
`default_nettype none
module twc_ram #(
	parameter int AW = 8,
	parameter int DW = 32
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [DW-1:0] wdata,
	input wire logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- sv/twc_cfg.sv -----
`default_nettype none
module twc_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [twc_pkg::CFG_IDXW-1:0] cfg_index,
	input wire logic [twc_pkg::CFGW-1:0] cfg_data,
	output twc_pkg::cfg_t cfg
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.l1_rd <= 16'd1;
			cfg.l1_wr <= 16'd1;
			cfg.l2_rd <= 16'd10;
			cfg.l2_wr <= 16'd10;
			cfg.mem_rd <= 16'd100;
			cfg.mem_wr <= 16'd100;
		end else if (cfg_we) begin
			unique case (cfg_index)
				twc_pkg::REG_L1_RD: cfg.l1_rd <= cfg_data;
				twc_pkg::REG_L1_WR: cfg.l1_wr <= cfg_data;
				twc_pkg::REG_L2_RD: cfg.l2_rd <= cfg_data;
				twc_pkg::REG_L2_WR: cfg.l2_wr <= cfg_data;
				twc_pkg::REG_MEM_RD: cfg.mem_rd <= cfg_data;
				twc_pkg::REG_MEM_WR: cfg.mem_wr <= cfg_data;
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- sv/two_level_writeback_cache_core.sv -----
`default_nettype none
// Two-level direct-mapped write-back cache. A request is taken when start is high and
// busy low; one result is strobed by done for a single cycle and must be taken then.
// After reset a clearing pass zeroes the backing memory, the data memories and the tag
// memories (one word of each per cycle), with busy high. Tags, valid and dirty bits
// sit in small synchronous memories read when the request is taken. A hit goes from
// LOOK1 straight to WORD and DONE, and busy is low again when done is strobed. Each
// 16-word block moved between stores goes through one port of the data memories, plus
// a LOOK2 step per L2 decision. The worst miss (dirty L1 victim whose L2 line holds
// another dirty block, then a fetch that evicts the victim again) moves six blocks.
module two_level_writeback_cache_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic func,
	input wire logic [15:0] byte_address,
	input wire logic [31:0] write_word,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [15:0] cfg_data,
	output logic done,
	output logic [31:0] read_word,
	output logic first_level_hit,
	output logic second_level_hit,
	output logic [19:0] access_cost,
	output logic [31:0] total_time
);
	twc_pkg::cfg_t cfg;
	twc_pkg::state_t state_q, state_d;

	twc_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cfg(cfg)
	);

	logic func_q;
	logic [13:0] waddr_q;
	logic [31:0] wword_q;
	logic [4:0] mcnt_q;
	logic [13:0] clr_q;
	logic [9:0] vblk_q;
	logic l1hit_q, l2hit_q, ndirty_q;
	logic [19:0] cost_q;
	logic [31:0] time_q;
	logic wb_pend_q; // 1: the pending L2 job is the L1 victim write, else the fetch
	logic claimed_q;
	twc_pkg::meta_t fm_q;

	wire [7:0] ni = waddr_q[11:4];
	wire [1:0] ntag = waddr_q[13:12];
	wire [3:0] wi = waddr_q[3:0];

	// memory ports
	logic n_we, f_we, m_we, nm_we, fm_we;
	logic [11:0] n_wa, n_ra, f_wa, f_ra;
	logic [13:0] m_wa, m_ra;
	logic [7:0] meta_wa, meta_ra;
	logic [31:0] n_wd, f_wd, m_wd, n_rd, f_rd, m_rd;
	twc_pkg::meta_t nm_wd, fm_wd, nm_rd, fm_rd;

	twc_ram #(.AW(12), .DW(32)) u_near (
		.clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));
	twc_ram #(.AW(12), .DW(32)) u_far (
		.clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
	twc_ram #(.AW(14), .DW(32)) u_mem (
		.clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
	twc_ram #(.AW(8), .DW($bits(twc_pkg::meta_t))) u_near_meta (
		.clk(clk), .we(nm_we), .waddr(meta_wa), .wdata(nm_wd), .raddr(meta_ra),
		.rdata(nm_rd));
	twc_ram #(.AW(8), .DW($bits(twc_pkg::meta_t))) u_far_meta (
		.clk(clk), .we(fm_we), .waddr(meta_wa), .wdata(fm_wd), .raddr(meta_ra),
		.rdata(fm_rd));

	// block copies: read word k at mcnt k, write word k-1 at mcnt k (1..16)
	wire [3:0] rk = mcnt_q[3:0];
	wire [3:0] wk = 4'(mcnt_q - 5'd1);
	wire wr_ph = (mcnt_q != 5'd0);
	wire last = (mcnt_q == 5'd16);
	wire l1h = nm_rd.valid && nm_rd.tag == ntag;
	wire [9:0] tblk = wb_pend_q ? vblk_q : waddr_q[13:4];
	wire l2h = fm_q.valid && fm_q.tag == tblk[9:8];
	wire nd_new = (func_q == twc_pkg::FUNC_WRITE) || (l1hit_q && ndirty_q);

	always_comb begin
		state_d = state_q;
		n_we = 1'b0; f_we = 1'b0; m_we = 1'b0; nm_we = 1'b0; fm_we = 1'b0;
		n_wa = {ni, wi}; n_ra = {ni, wi}; n_wd = wword_q;
		f_wa = {ni, wk}; f_ra = {ni, rk}; f_wd = n_rd;
		m_wa = {fm_q.tag, ni, wk}; m_ra = {vblk_q, rk}; m_wd = f_rd;
		meta_wa = ni; meta_ra = ni;
		nm_wd = {1'b1, nd_new, ntag};
		fm_wd = fm_q;
		busy = 1'b1;
		unique case (state_q)
			twc_pkg::ST_CLEAR: begin
				n_we = 1'b1; f_we = 1'b1; m_we = 1'b1; nm_we = 1'b1; fm_we = 1'b1;
				n_wa = clr_q[11:0]; f_wa = clr_q[11:0]; m_wa = clr_q;
				meta_wa = clr_q[7:0];
				n_wd = '0; f_wd = '0; m_wd = '0; nm_wd = '0; fm_wd = '0;
				if (clr_q == 14'h3FFF) state_d = twc_pkg::ST_IDLE;
			end
			twc_pkg::ST_IDLE: begin
				busy = 1'b0;
				meta_ra = byte_address[13:6];
				if (start) state_d = twc_pkg::ST_LOOK1;
			end
			twc_pkg::ST_LOOK1: begin
				state_d = l1h ? twc_pkg::ST_WORD : twc_pkg::ST_LOOK2;
			end
			twc_pkg::ST_LOOK2: begin
				if (claimed_q || l2h)
					state_d = wb_pend_q ? twc_pkg::ST_N2F : twc_pkg::ST_F2N;
				else
					state_d = fm_q.dirty ? twc_pkg::ST_F2M : twc_pkg::ST_M2F;
			end
			twc_pkg::ST_N2F: begin
				n_ra = {ni, rk};
				f_we = wr_ph;
				if (last) state_d = twc_pkg::ST_LOOK2;
			end
			twc_pkg::ST_F2M: begin
				m_we = wr_ph;
				if (last) state_d = twc_pkg::ST_M2F;
			end
			twc_pkg::ST_M2F: begin
				f_we = wr_ph; f_wd = m_rd;
				if (last) state_d = twc_pkg::ST_LOOK2;
			end
			twc_pkg::ST_F2N: begin
				n_we = wr_ph; n_wa = {ni, wk}; n_wd = f_rd;
				if (last) state_d = twc_pkg::ST_WORD;
			end
			twc_pkg::ST_WORD: begin
				n_we = func_q;
				nm_we = 1'b1;
				fm_we = 1'b1;
				state_d = twc_pkg::ST_DONE;
			end
			twc_pkg::ST_DONE: state_d = twc_pkg::ST_IDLE;
			default: state_d = twc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= twc_pkg::ST_CLEAR;
			clr_q <= '0;
			func_q <= 1'b0;
			waddr_q <= '0;
			wword_q <= '0;
			mcnt_q <= '0;
			vblk_q <= '0;
			l1hit_q <= 1'b0;
			l2hit_q <= 1'b0;
			ndirty_q <= 1'b0;
			cost_q <= '0;
			time_q <= '0;
			wb_pend_q <= 1'b0;
			claimed_q <= 1'b0;
			fm_q <= '0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= 1'b0;
			unique case (state_q)
				twc_pkg::ST_CLEAR: clr_q <= 14'(clr_q + 14'd1);
				twc_pkg::ST_IDLE: if (start) begin
					func_q <= func;
					waddr_q <= byte_address[15:2];
					wword_q <= write_word;
					cost_q <= '0;
					l2hit_q <= 1'b0;
					mcnt_q <= '0;
					claimed_q <= 1'b0;
				end
				twc_pkg::ST_LOOK1: begin
					l1hit_q <= l1h;
					ndirty_q <= nm_rd.dirty;
					wb_pend_q <= nm_rd.dirty && !l1h;
					vblk_q <= {nm_rd.tag, ni};
					fm_q <= fm_rd;
				end
				twc_pkg::ST_LOOK2: begin
					if (claimed_q || l2h) begin
						claimed_q <= 1'b0;
						if (!wb_pend_q) l2hit_q <= !claimed_q;
					end else begin
						vblk_q <= tblk;
					end
				end
				twc_pkg::ST_N2F, twc_pkg::ST_F2M, twc_pkg::ST_M2F, twc_pkg::ST_F2N: begin
					mcnt_q <= last ? 5'd0 : 5'(mcnt_q + 5'd1);
					if (last) begin
						unique case (state_q)
							twc_pkg::ST_N2F: begin
								fm_q.dirty <= 1'b1;
								cost_q <= cost_q + 20'(cfg.l2_wr);
								wb_pend_q <= 1'b0;
							end
							twc_pkg::ST_F2M: cost_q <= cost_q + 20'(cfg.mem_wr);
							twc_pkg::ST_M2F: begin
								fm_q <= '{valid: 1'b1, dirty: 1'b0, tag: vblk_q[9:8]};
								cost_q <= cost_q + 20'(cfg.mem_rd);
								claimed_q <= 1'b1;
							end
							default: cost_q <= cost_q + 20'(cfg.l2_rd);
						endcase
					end
				end
				twc_pkg::ST_WORD: begin
					if (func_q == twc_pkg::FUNC_WRITE)
						cost_q <= cost_q + 20'(cfg.l1_wr);
					else
						cost_q <= cost_q + 20'(cfg.l1_rd);
				end
				twc_pkg::ST_DONE: begin
					done <= 1'b1;
					time_q <= time_q + 32'(cost_q);
				end
				default: ;
			endcase
		end
	end

	// near read of the word: issued in WORD, data valid in DONE
	logic [31:0] rword_q;
	always_ff @(posedge clk) begin
		if (state_q == twc_pkg::ST_DONE) begin
			rword_q <= (func_q == twc_pkg::FUNC_WRITE) ? 32'd0 : n_rd;
			access_cost <= cost_q;
			first_level_hit <= l1hit_q;
			second_level_hit <= l2hit_q;
		end
	end
	assign read_word = rword_q;
	assign total_time = time_q;
endmodule
`default_nettype wire

// ----- sv/twc_checker.sv -----
`default_nettype none
module twc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic first_level_hit,
	input wire logic second_level_hit,
	input wire logic [19:0] access_cost,
	input wire logic [31:0] total_time
);
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held");
	a_hit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(first_level_hit && second_level_hit)) else $error("both hits");
	a_time: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> total_time == 32'($past(total_time) + 32'(access_cost)))
		else $error("time");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("not busy");
endmodule

bind two_level_writeback_cache_core twc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.first_level_hit(first_level_hit), .second_level_hit(second_level_hit),
	.access_cost(access_cost), .total_time(total_time)
);
`default_nettype wire
